[hdl/svd_pkg.sv]
`timescale 1ns / 1ps
package svd_pkg;

  localparam int XW      = 24;
  localparam int RW      = 24;
  localparam int QW      = 16;
  localparam int CW      = 33;
  localparam int NSTEPS  = 16;
  localparam int FRACW   = 26;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_AMP    = 3'd3;
  localparam logic [2:0] REG_FREQ   = 3'd4;
  localparam logic [2:0] REG_PHASE  = 3'd5;

  localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;

  typedef struct packed {
    logic valid;
    logic zero;
    logic sat;
  } div_flags_t;

  function automatic logic [29:0] atan_lut(input logic [3:0] i);
    logic [29:0] r;
    unique case (i)
      4'd0:  r = 30'h20000000;
      4'd1:  r = 30'h12E4051E;
      4'd2:  r = 30'h09FB385B;
      4'd3:  r = 30'h051111D4;
      4'd4:  r = 30'h028B0D43;
      4'd5:  r = 30'h0145D7E1;
      4'd6:  r = 30'h00A2F61E;
      4'd7:  r = 30'h00517C55;
      4'd8:  r = 30'h0028BE53;
      4'd9:  r = 30'h00145F2F;
      4'd10: r = 30'h000A2F98;
      4'd11: r = 30'h000517CC;
      4'd12: r = 30'h00028BE6;
      4'd13: r = 30'h000145F3;
      4'd14: r = 30'h0000A2FA;
      default: r = 30'h0000517D;
    endcase
    return r;
  endfunction

endpackage

[hdl/svd_div_cell.sv]
`timescale 1ns / 1ps
module svd_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [svd_pkg::RW-1:0]    w,
  input  svd_pkg::div_flags_t       flags_in,
  input  logic [svd_pkg::RW-1:0]    r_in,
  input  logic [svd_pkg::QW-1:0]    q_in,
  output svd_pkg::div_flags_t       flags_out,
  output logic [svd_pkg::RW-1:0]    r_out,
  output logic [svd_pkg::QW-1:0]    q_out
);

  logic [svd_pkg::RW-1:0] r2;
  logic                   ge;

  assign r2 = {r_in[svd_pkg::RW-2:0], 1'b0};
  assign ge = (r2 >= w);

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else if (en) begin
      flags_out <= flags_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= ge ? (r2 - w) : r2;
      q_out <= {q_in[svd_pkg::QW-2:0], ge};
    end
  end

endmodule

[hdl/svd_cordic_cell.sv]
`timescale 1ns / 1ps
module svd_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          v_in,
  input  logic signed [svd_pkg::CW-1:0] x_in,
  input  logic signed [svd_pkg::CW-1:0] y_in,
  input  logic signed [svd_pkg::CW-1:0] t_in,
  output logic                          v_out,
  output logic signed [svd_pkg::CW-1:0] x_out,
  output logic signed [svd_pkg::CW-1:0] y_out,
  output logic signed [svd_pkg::CW-1:0] t_out
);

  logic signed [svd_pkg::CW-1:0] dx, dy, at;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;
  assign at = signed'({3'b000, svd_pkg::atan_lut(4'(STEP))});

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!t_in[svd_pkg::CW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        t_out <= t_in - at;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        t_out <= t_in + at;
      end
    end
  end

endmodule

[hdl/sine_wave_vertical_displacement_unit.sv]
`timescale 1ns / 1ps
// Sine-wave vertical displacement. Each anchor_x beat yields one displacement_y
// beat; one beat is taken per cycle, and the whole pipeline holds while a
// result waits at the output. Progress comes from a 16-cell restoring divider,
// the sine from a 16-cell CORDIC, and the scaling from a two-stage split
// multiply. Registers are written over APB at 4*index and must only change
// while no beats are in flight.
module sine_wave_vertical_displacement_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] anchor_x,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] displacement_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N  = svd_pkg::NSTEPS;
  localparam int CW = svd_pkg::CW;

  logic [23:0] reg_left;
  logic [22:0] reg_width, reg_height;
  logic [16:0] reg_amp, reg_phase;
  logic [14:0] reg_freq;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_left   <= '0;
      reg_width  <= 23'd256;
      reg_height <= 23'd256;
      reg_amp    <= '0;
      reg_freq   <= '0;
      reg_phase  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        svd_pkg::REG_LEFT:   reg_left   <= pwdata[23:0];
        svd_pkg::REG_WIDTH:  reg_width  <= pwdata[22:0];
        svd_pkg::REG_HEIGHT: reg_height <= pwdata[22:0];
        svd_pkg::REG_AMP:    reg_amp    <= pwdata[16:0];
        svd_pkg::REG_FREQ:   reg_freq   <= pwdata[14:0];
        svd_pkg::REG_PHASE:  reg_phase  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      svd_pkg::REG_LEFT:   prdata = {8'd0, reg_left};
      svd_pkg::REG_WIDTH:  prdata = {9'd0, reg_width};
      svd_pkg::REG_HEIGHT: prdata = {9'd0, reg_height};
      svd_pkg::REG_AMP:    prdata = {15'd0, reg_amp};
      svd_pkg::REG_FREQ:   prdata = {17'd0, reg_freq};
      svd_pkg::REG_PHASE:  prdata = {15'd0, reg_phase};
      default:             prdata = '0;
    endcase
  end

  // effective (clamped) settings
  logic [23:0] w_c;
  logic [16:0] amp_c;
  logic [14:0] freq_c;
  logic signed [16:0] ph_c;

  assign w_c    = (reg_width < 23'd256) ? 24'd256 : {1'b0, reg_width};
  assign amp_c  = (reg_amp > 17'd65536) ? 17'd65536 : reg_amp;
  assign freq_c = (reg_freq > 15'd20480) ? 15'd20480 : reg_freq;
  always_comb begin
    ph_c = signed'(reg_phase);
    if (ph_c > 17'sd32768) ph_c = 17'sd32768;
    else if (ph_c < -17'sd32768) ph_c = -17'sd32768;
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // entry: difference and range flags
  logic signed [24:0] diff;
  assign diff = 25'(signed'(anchor_x)) - 25'(signed'(reg_left));

  svd_pkg::div_flags_t     df [0:N];
  logic [svd_pkg::RW-1:0]  dr [0:N];
  logic [svd_pkg::QW-1:0]  dq [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      df[0] <= '0;
    end else if (en) begin
      df[0].valid <= in_valid;
      df[0].zero  <= (diff <= 25'sd0);
      df[0].sat   <= (diff > 25'sd0) && (diff[23:0] >= w_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0] <= {1'b0, diff[22:0]};
      dq[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_div
    svd_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .w(w_c),
      .flags_in(df[i]), .r_in(dr[i]), .q_in(dq[i]),
      .flags_out(df[i+1]), .r_out(dr[i+1]), .q_out(dq[i+1])
    );
  end

  // frequency times progress
  logic [16:0] prog;
  logic [31:0] fp;
  logic        v_fp;

  always_comb begin
    if (df[N].sat)       prog = 17'd65536;
    else if (df[N].zero) prog = '0;
    else                 prog = {1'b0, dq[N]};
  end

  always_ff @(posedge clk) begin
    if (rst) v_fp <= 1'b0;
    else if (en) v_fp <= df[N].valid;
  end
  always_ff @(posedge clk) begin
    if (en) fp <= 32'(freq_c * prog);
  end

  // phase add, wrap and quadrant fold
  logic [svd_pkg::FRACW-1:0] frac;
  logic [ANGLE_BITS-1:0]     ang;
  logic signed [CW-1:0]      t0, tf;

  assign frac = fp[svd_pkg::FRACW-1:0] + {ph_c[14:0], 11'd0};
  assign ang  = frac[svd_pkg::FRACW-1 -: ANGLE_BITS];
  always_comb begin
    t0 = CW'(signed'({ang, {(32-ANGLE_BITS){1'b0}}}));
    if (t0 > 33'sh040000000)       tf = 33'sh080000000 - t0;
    else if (t0 < -33'sh040000000) tf = -33'sh080000000 - t0;
    else                           tf = t0;
  end

  logic                 cv [0:N];
  logic signed [CW-1:0] cx [0:N];
  logic signed [CW-1:0] cy [0:N];
  logic signed [CW-1:0] ct [0:N];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (en) cv[0] <= v_fp;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= svd_pkg::CORDIC_X0;
      cy[0] <= '0;
      ct[0] <= tf;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    svd_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(cv[i]), .x_in(cx[i]), .y_in(cy[i]), .t_in(ct[i]),
      .v_out(cv[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]), .t_out(ct[i+1])
    );
  end

  // Q1.15 rounding and magnitude
  logic signed [CW-1:0] yr;
  logic signed [17:0]   sr;
  logic [15:0]          s_abs;
  logic                 s_neg, v_s;

  assign yr = (cy[N] + 33'sd16384) >>> 15;
  assign sr = yr[17:0];

  always_ff @(posedge clk) begin
    if (rst) v_s <= 1'b0;
    else if (en) v_s <= cv[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s_neg <= sr[17];
      if (sr > 18'sd32767)       s_abs <= 16'd32767;
      else if (sr < -18'sd32768) s_abs <= 16'd32768;
      else if (sr[17])           s_abs <= 16'(-sr);
      else                       s_abs <= sr[15:0];
    end
  end

  // height times |sine|
  logic [38:0] p1;
  logic        neg1, v_p1;

  always_ff @(posedge clk) begin
    if (rst) v_p1 <= 1'b0;
    else if (en) v_p1 <= v_s;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= 39'(reg_height * s_abs);
      neg1 <= s_neg;
    end
  end

  // amplitude, split in two partial products
  logic [35:0] pl;
  logic [34:0] ph;
  logic [38:0] p2;
  logic        full2, neg2, v_p2;

  always_ff @(posedge clk) begin
    if (rst) v_p2 <= 1'b0;
    else if (en) v_p2 <= v_p1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pl    <= 36'(amp_c[15:0] * p1[19:0]);
      ph    <= 35'(amp_c[15:0] * p1[38:20]);
      p2    <= p1;
      full2 <= amp_c[16];
      neg2  <= neg1;
    end
  end

  logic [55:0] mag;
  logic [24:0] mr, ms;
  logic signed [24:0] res;

  always_comb begin
    if (full2) mag = {1'b0, p2, 16'd0};
    else       mag = {1'b0, ph, 20'd0} + {20'd0, pl};
    mr  = 25'((mag + 56'd1073741824) >> 31);
    ms  = (mr > 25'd8388608) ? 25'd8388608 : mr;
    res = neg2 ? -signed'(ms) : signed'(ms);
    if (res > 25'sd8388607) res = 25'sd8388607;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_p2;
  end
  always_ff @(posedge clk) begin
    if (en) displacement_y <= res[23:0];
  end

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !cv[0] && !df[0].valid)
    else $error("pipeline valid not cleared by reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cv[N]) && $stable(v_fp) && $stable(v_p2))
    else $error("pipeline moved during stall");
  a_free_ready: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with empty output");
`endif

endmodule
